// ===== rtl/pdbd_pkg.sv =====
// Shared types, constants and the dither function of the pixel doubler.
package pdbd_pkg;

    localparam int COORD_W = 11;
    localparam int PROD_W  = 22;
    localparam int ADDR_W  = 19;
    localparam int CFG_W   = 9;
    localparam int INDEX_W = 3;

    localparam logic [2:0] LEVEL3_MASK = 3'h7;
    localparam logic [1:0] LEVEL2_MASK = 2'h3;
    localparam logic [4:0] LEVEL_FULL  = 5'd16;
    localparam logic [7:0] RED_BIT     = 8'h80;
    localparam logic [7:0] GREEN_BIT   = 8'h10;
    localparam logic [7:0] BLUE_BIT    = 8'h02;

    localparam logic [3:0] BAYER [0:3][0:3] = '{
        '{4'd0,  4'd8,  4'd2,  4'd10},
        '{4'd12, 4'd4,  4'd14, 4'd6},
        '{4'd3,  4'd11, 4'd1,  4'd9},
        '{4'd15, 4'd7,  4'd13, 4'd5}
    };

    typedef enum logic [INDEX_W-1:0] {
        REG_SOURCE_WIDTH   = 3'd0,
        REG_SOURCE_HEIGHT  = 3'd1,
        REG_DITHER_ENABLE  = 3'd2,
        REG_REGION_X_FIRST = 3'd3,
        REG_REGION_Y_FIRST = 3'd4,
        REG_REGION_X_LAST  = 3'd5,
        REG_REGION_Y_LAST  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [8:0] source_width;
        logic [7:0] source_height;
        logic       dither_enable;
        logic [8:0] region_x_first;
        logic [7:0] region_y_first;
        logic [8:0] region_x_last;
        logic [7:0] region_y_last;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic       ok;
        logic [7:0] colour;
        logic [8:0] sx;
        logic [7:0] sy;
    } s1_t;

    typedef struct packed {
        logic               valid;
        logic               ok;
        logic [7:0]         colour;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } s2_t;

    function automatic logic [4:0] scale3(input logic [2:0] v);
        logic [4:0] s;
        s = (v == LEVEL3_MASK) ? LEVEL_FULL : {1'b0, v, 1'b0};
        return s;
    endfunction

    function automatic logic [7:0] dither_pixel(input logic [7:0] colour,
                                                input logic [1:0] tx,
                                                input logic [1:0] ty);
        logic [4:0] thr;
        logic [4:0] rv;
        logic [4:0] gv;
        logic [4:0] bv;
        logic [7:0] res;
        thr = {1'b0, BAYER[ty][tx]};
        rv  = scale3(colour[7:5] & LEVEL3_MASK);
        gv  = scale3(colour[4:2] & LEVEL3_MASK);
        bv  = ((colour[1:0] & LEVEL2_MASK) == LEVEL2_MASK) ? LEVEL_FULL
                                                           : {1'b0, colour[1:0], 2'b00};
        res = 8'h00;
        if (rv > thr)
        begin
            res = res | RED_BIT;
        end
        if (gv > thr)
        begin
            res = res | GREEN_BIT;
        end
        if (bv > thr)
        begin
            res = res | BLUE_BIT;
        end
        return res;
    endfunction

endpackage

// ===== rtl/pixel_double_bayer_dither_top.sv =====
// Top level of the pixel doubler with 4x4 ordered dither.
// Pipeline: a taken beat shows its result with done high after it passes three register
// stages: region test, placement, address/dither.
// Throughput: one beat per cycle; busy stays low and the result cannot be held off.
// Reset: rst_n clears all valid bits and loads the register defaults.
module pixel_double_bayer_dither_top #(
    parameter int OUT_WIDTH  = 640,
    parameter int OUT_HEIGHT = 480
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [7:0]                           pixel_colour,
    input  logic [8:0]                           source_x,
    input  logic [7:0]                           source_y,
    input  logic                                 cfg_we,
    input  logic [pdbd_pkg::INDEX_W-1:0]         cfg_index,
    input  logic [pdbd_pkg::CFG_W-1:0]           cfg_data,
    output logic                                 done,
    output logic                                 accepted,
    output logic [pdbd_pkg::ADDR_W-1:0]          top_row_address,
    output logic [pdbd_pkg::ADDR_W-1:0]          bottom_row_address,
    output logic [7:0]                           pixel_top_left,
    output logic [7:0]                           pixel_top_right,
    output logic [7:0]                           pixel_bottom_left,
    output logic [7:0]                           pixel_bottom_right
);

    pdbd_pkg::cfg_t cfg_reg;
    pdbd_pkg::s1_t  s1;
    pdbd_pkg::s2_t  s2;
    logic           in_valid;

    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_width   <= 9'd320;
            cfg_reg.source_height  <= 8'd240;
            cfg_reg.dither_enable  <= 1'b0;
            cfg_reg.region_x_first <= 9'd0;
            cfg_reg.region_y_first <= 8'd0;
            cfg_reg.region_x_last  <= 9'd319;
            cfg_reg.region_y_last  <= 8'd239;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pdbd_pkg::REG_SOURCE_WIDTH:   cfg_reg.source_width   <= cfg_data;
                pdbd_pkg::REG_SOURCE_HEIGHT:  cfg_reg.source_height  <= cfg_data[7:0];
                pdbd_pkg::REG_DITHER_ENABLE:  cfg_reg.dither_enable  <= cfg_data[0];
                pdbd_pkg::REG_REGION_X_FIRST: cfg_reg.region_x_first <= cfg_data;
                pdbd_pkg::REG_REGION_Y_FIRST: cfg_reg.region_y_first <= cfg_data[7:0];
                pdbd_pkg::REG_REGION_X_LAST:  cfg_reg.region_x_last  <= cfg_data;
                pdbd_pkg::REG_REGION_Y_LAST:  cfg_reg.region_y_last  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    pdbd_check #(
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .pixel_colour (pixel_colour),
        .source_x     (source_x),
        .source_y     (source_y),
        .cfg          (cfg_reg),
        .s1           (s1)
    );

    pdbd_place #(
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT)
    ) u_place (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1),
        .cfg   (cfg_reg),
        .s2    (s2)
    );

    pdbd_emit #(
        .OUT_WIDTH (OUT_WIDTH)
    ) u_emit (
        .clk                (clk),
        .rst_n              (rst_n),
        .s2                 (s2),
        .dither_enable      (cfg_reg.dither_enable),
        .done               (done),
        .accepted           (accepted),
        .top_row_address    (top_row_address),
        .bottom_row_address (bottom_row_address),
        .pixel_top_left     (pixel_top_left),
        .pixel_top_right    (pixel_top_right),
        .pixel_bottom_left  (pixel_bottom_left),
        .pixel_bottom_right (pixel_bottom_right)
    );

endmodule

// ===== rtl/pdbd_check.sv =====
// Stage one: frame geometry and clipped region test.
module pdbd_check #(
    parameter int OUT_WIDTH  = 640,
    parameter int OUT_HEIGHT = 480
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [7:0]       pixel_colour,
    input  logic [8:0]       source_x,
    input  logic [7:0]       source_y,
    input  pdbd_pkg::cfg_t   cfg,
    output pdbd_pkg::s1_t    s1
);

    pdbd_pkg::s1_t s1_reg;
    pdbd_pkg::s1_t s1_next;
    logic          geo_ok;
    logic          x_ok;
    logic          y_ok;

    always_comb
    begin
        geo_ok = (cfg.source_width != 9'd0) && (cfg.source_height != 8'd0)
              && ({2'b00, cfg.source_width, 1'b0} <= 12'(OUT_WIDTH))
              && ({3'b000, cfg.source_height, 1'b0} <= 12'(OUT_HEIGHT));
        x_ok = (source_x >= cfg.region_x_first) && (source_x <= cfg.region_x_last)
            && (source_x < cfg.source_width);
        y_ok = (source_y >= cfg.region_y_first) && (source_y <= cfg.region_y_last)
            && (source_y < cfg.source_height);
        s1_next.valid  = in_valid;
        s1_next.ok     = geo_ok && x_ok && y_ok;
        s1_next.colour = pixel_colour;
        s1_next.sx     = source_x;
        s1_next.sy     = source_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

// ===== rtl/pdbd_place.sv =====
// Stage two: output frame coordinates of the doubled pixel.
module pdbd_place #(
    parameter int OUT_WIDTH  = 640,
    parameter int OUT_HEIGHT = 480
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pdbd_pkg::s1_t  s1,
    input  pdbd_pkg::cfg_t cfg,
    output pdbd_pkg::s2_t  s2
);

    localparam int CW = pdbd_pkg::COORD_W;
    localparam logic [CW-1:0] HALF_W = CW'(OUT_WIDTH / 2);
    localparam logic [CW-1:0] HALF_H = CW'(OUT_HEIGHT / 2);

    pdbd_pkg::s2_t s2_reg;
    pdbd_pkg::s2_t s2_next;

    always_comb
    begin
        s2_next.valid  = s1.valid;
        s2_next.ok     = s1.ok;
        s2_next.colour = s1.colour;
        s2_next.px     = HALF_W - CW'(cfg.source_width) + CW'({s1.sx, 1'b0});
        s2_next.py     = HALF_H - CW'(cfg.source_height) + CW'({s1.sy, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

// ===== rtl/pdbd_emit.sv =====
// Stage three: frame-buffer addresses, dither and the result register.
module pdbd_emit #(
    parameter int OUT_WIDTH = 640
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pdbd_pkg::s2_t                 s2,
    input  logic                          dither_enable,
    output logic                          done,
    output logic                          accepted,
    output logic [pdbd_pkg::ADDR_W-1:0]   top_row_address,
    output logic [pdbd_pkg::ADDR_W-1:0]   bottom_row_address,
    output logic [7:0]                    pixel_top_left,
    output logic [7:0]                    pixel_top_right,
    output logic [7:0]                    pixel_bottom_left,
    output logic [7:0]                    pixel_bottom_right
);

    localparam int PW = pdbd_pkg::PROD_W;
    localparam int AW = pdbd_pkg::ADDR_W;

    logic [PW-1:0] row_base;
    logic [PW-1:0] top_full;
    logic [PW-1:0] bot_full;
    logic [1:0]    tx0;
    logic [1:0]    tx1;
    logic [1:0]    ty0;
    logic [1:0]    ty1;

    logic          done_reg;
    logic          accepted_reg;
    logic [AW-1:0] top_reg;
    logic [AW-1:0] bot_reg;
    logic [7:0]    tl_reg;
    logic [7:0]    tr_reg;
    logic [7:0]    bl_reg;
    logic [7:0]    br_reg;

    logic          accepted_next;
    logic [AW-1:0] top_next;
    logic [AW-1:0] bot_next;
    logic [7:0]    tl_next;
    logic [7:0]    tr_next;
    logic [7:0]    bl_next;
    logic [7:0]    br_next;

    always_comb
    begin
        row_base = PW'(s2.py) * PW'(OUT_WIDTH);
        top_full = row_base + PW'(s2.px);
        bot_full = top_full + PW'(OUT_WIDTH);
        tx0 = s2.px[1:0];
        tx1 = s2.px[1:0] + 2'd1;
        ty0 = s2.py[1:0];
        ty1 = s2.py[1:0] + 2'd1;

        accepted_next = s2.ok;
        top_next = '0;
        bot_next = '0;
        tl_next  = 8'h00;
        tr_next  = 8'h00;
        bl_next  = 8'h00;
        br_next  = 8'h00;
        if (s2.ok)
        begin
            top_next = top_full[AW-1:0];
            bot_next = bot_full[AW-1:0];
            if (dither_enable)
            begin
                tl_next = pdbd_pkg::dither_pixel(s2.colour, tx0, ty0);
                tr_next = pdbd_pkg::dither_pixel(s2.colour, tx1, ty0);
                bl_next = pdbd_pkg::dither_pixel(s2.colour, tx0, ty1);
                br_next = pdbd_pkg::dither_pixel(s2.colour, tx1, ty1);
            end
            else
            begin
                tl_next = s2.colour;
                tr_next = s2.colour;
                bl_next = s2.colour;
                br_next = s2.colour;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        accepted_reg <= accepted_next;
        top_reg      <= top_next;
        bot_reg      <= bot_next;
        tl_reg       <= tl_next;
        tr_reg       <= tr_next;
        bl_reg       <= bl_next;
        br_reg       <= br_next;
    end

    assign done               = done_reg;
    assign accepted           = accepted_reg;
    assign top_row_address    = top_reg;
    assign bottom_row_address = bot_reg;
    assign pixel_top_left     = tl_reg;
    assign pixel_top_right    = tr_reg;
    assign pixel_bottom_left  = bl_reg;
    assign pixel_bottom_right = br_reg;

endmodule

// ===== rtl/pdbd_checker.sv =====
// Port-level checker for the pixel doubler and its bind to the top level.
module pdbd_checker #(
    parameter int OUT_WIDTH = 640
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        accepted,
    input logic [pdbd_pkg::ADDR_W-1:0] top_row_address,
    input logic [pdbd_pkg::ADDR_W-1:0] bottom_row_address,
    input logic [7:0]                  pixel_top_left,
    input logic [7:0]                  pixel_top_right,
    input logic [7:0]                  pixel_bottom_left,
    input logic [7:0]                  pixel_bottom_right
);

    localparam int AW = pdbd_pkg::ADDR_W;

    a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("beat did not produce a result three cycles later");

    a_result_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result without a matching beat");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !accepted) |-> (top_row_address == '0 && bottom_row_address == '0
            && pixel_top_left == 8'h00 && pixel_top_right == 8'h00
            && pixel_bottom_left == 8'h00 && pixel_bottom_right == 8'h00))
        else $error("rejected pixel carries nonzero payload");

    a_bottom_row: assert property (@(posedge clk) disable iff (!rst_n)
        (done && accepted) |->
            (bottom_row_address == AW'({1'b0, top_row_address} + (AW+1)'(OUT_WIDTH))))
        else $error("bottom row address is not one line below the top row");

endmodule

bind pixel_double_bayer_dither_top pdbd_checker #(
    .OUT_WIDTH (OUT_WIDTH)
) u_pdbd_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .done               (done),
    .accepted           (accepted),
    .top_row_address    (top_row_address),
    .bottom_row_address (bottom_row_address),
    .pixel_top_left     (pixel_top_left),
    .pixel_top_right    (pixel_top_right),
    .pixel_bottom_left  (pixel_bottom_left),
    .pixel_bottom_right (pixel_bottom_right)
);

// ===== sim/pixel_double_bayer_dither_top_test.sv =====
// Self-checking testbench for the pixel doubler with 4x4 ordered dither.
`timescale 1ns / 1ps

module pixel_double_bayer_dither_top_test;

    localparam int OUT_W        = 640;
    localparam int OUT_H        = 480;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;
    localparam int GAP_PERCENT  = 8;
    localparam int PHASES       = 16;
    localparam int PHASE_BEATS  = 100;

    localparam logic [3:0] THRESHOLD [0:3][0:3] = '{
        '{4'd0,  4'd8,  4'd2,  4'd10},
        '{4'd12, 4'd4,  4'd14, 4'd6},
        '{4'd3,  4'd11, 4'd1,  4'd9},
        '{4'd15, 4'd7,  4'd13, 4'd5}
    };

    typedef struct packed {
        logic        accepted;
        logic [18:0] top;
        logic [18:0] bottom;
        logic [7:0]  tl;
        logic [7:0]  tr;
        logic [7:0]  bl;
        logic [7:0]  br;
    } block_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [7:0]                    pixel_colour;
    logic [8:0]                    source_x;
    logic [7:0]                    source_y;
    logic                          cfg_we;
    logic [pdbd_pkg::INDEX_W-1:0]  cfg_index;
    logic [pdbd_pkg::CFG_W-1:0]    cfg_data;
    logic                          done;
    logic                          accepted;
    logic [pdbd_pkg::ADDR_W-1:0]   top_row_address;
    logic [pdbd_pkg::ADDR_W-1:0]   bottom_row_address;
    logic [7:0]                    pixel_top_left;
    logic [7:0]                    pixel_top_right;
    logic [7:0]                    pixel_bottom_left;
    logic [7:0]                    pixel_bottom_right;

    pdbd_pkg::cfg_t frame_cfg;
    block_t         expected_blocks [$];
    logic           steady;
    int             cycle_count;
    int             beats_checked;
    int             blocks_written;
    int             mismatches;
    int             pixels_sent;
    int             settings_used;

    pixel_double_bayer_dither_top #(
        .OUT_WIDTH  (OUT_W),
        .OUT_HEIGHT (OUT_H)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .pixel_colour       (pixel_colour),
        .source_x           (source_x),
        .source_y           (source_y),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .done               (done),
        .accepted           (accepted),
        .top_row_address    (top_row_address),
        .bottom_row_address (bottom_row_address),
        .pixel_top_left     (pixel_top_left),
        .pixel_top_right    (pixel_top_right),
        .pixel_bottom_left  (pixel_bottom_left),
        .pixel_bottom_right (pixel_bottom_right)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] dither_one(input logic [7:0] colour, input int ox,
                                              input int oy);
        int         thr;
        int         red_level;
        int         green_level;
        int         blue_level;
        logic [7:0] bits;
        thr         = THRESHOLD[oy & 3][ox & 3];
        red_level   = (colour[7:5] == 3'd7) ? 16 : 2 * int'(colour[7:5]);
        green_level = (colour[4:2] == 3'd7) ? 16 : 2 * int'(colour[4:2]);
        blue_level  = (colour[1:0] == 2'd3) ? 16 : 4 * int'(colour[1:0]);
        bits = 8'h00;
        if (red_level > thr)
        begin
            bits[7] = 1'b1;
        end
        if (green_level > thr)
        begin
            bits[4] = 1'b1;
        end
        if (blue_level > thr)
        begin
            bits[1] = 1'b1;
        end
        return bits;
    endfunction

    function automatic block_t predict_block(input pdbd_pkg::cfg_t c, input logic [7:0] colour,
                                             input logic [8:0] x, input logic [7:0] y);
        block_t r;
        int     w;
        int     h;
        int     x_end;
        int     y_end;
        int     px;
        int     py;
        int     top;
        int     bottom;
        r = '0;
        w = int'(c.source_width);
        h = int'(c.source_height);
        if (w == 0 || h == 0 || 2 * w > OUT_W || 2 * h > OUT_H)
        begin
            return r;
        end
        x_end = int'(c.region_x_last);
        if (x_end > w - 1)
        begin
            x_end = w - 1;
        end
        y_end = int'(c.region_y_last);
        if (y_end > h - 1)
        begin
            y_end = h - 1;
        end
        if (int'(x) < int'(c.region_x_first) || int'(x) > x_end ||
            int'(y) < int'(c.region_y_first) || int'(y) > y_end)
        begin
            return r;
        end
        px     = (OUT_W - 2 * w) / 2 + 2 * int'(x);
        py     = (OUT_H - 2 * h) / 2 + 2 * int'(y);
        top    = py * OUT_W + px;
        bottom = top + OUT_W;
        r.accepted = 1'b1;
        r.top      = top[18:0];
        r.bottom   = bottom[18:0];
        if (c.dither_enable)
        begin
            r.tl = dither_one(colour, px, py);
            r.tr = dither_one(colour, px + 1, py);
            r.bl = dither_one(colour, px, py + 1);
            r.br = dither_one(colour, px + 1, py + 1);
        end
        else
        begin
            r.tl = colour;
            r.tr = colour;
            r.bl = colour;
            r.br = colour;
        end
        return r;
    endfunction

    task automatic write_reg(input pdbd_pkg::reg_index_t idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[pdbd_pkg::CFG_W-1:0];
        @(negedge clk);
    endtask

    task automatic set_frame(input int w, input int h, input int d, input int xf,
                             input int yf, input int xl, input int yl);
        write_reg(pdbd_pkg::REG_SOURCE_WIDTH, w);
        write_reg(pdbd_pkg::REG_SOURCE_HEIGHT, h);
        write_reg(pdbd_pkg::REG_DITHER_ENABLE, d);
        write_reg(pdbd_pkg::REG_REGION_X_FIRST, xf);
        write_reg(pdbd_pkg::REG_REGION_Y_FIRST, yf);
        write_reg(pdbd_pkg::REG_REGION_X_LAST, xl);
        write_reg(pdbd_pkg::REG_REGION_Y_LAST, yl);
        cfg_we <= 1'b0;
        frame_cfg.source_width   = w[8:0];
        frame_cfg.source_height  = h[7:0];
        frame_cfg.dither_enable  = d[0];
        frame_cfg.region_x_first = xf[8:0];
        frame_cfg.region_y_first = yf[7:0];
        frame_cfg.region_x_last  = xl[8:0];
        frame_cfg.region_y_last  = yl[7:0];
        settings_used++;
    endtask

    task automatic send_pixel(input logic [7:0] colour, input logic [8:0] x,
                              input logic [7:0] y);
        logic taken;
        while (!steady && $urandom_range(99) < GAP_PERCENT)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        pixel_colour <= colour;
        source_x     <= x;
        source_y     <= y;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            if (!busy)
            begin
                taken = 1'b1;
                expected_blocks.push_back(predict_block(frame_cfg, colour, x, y));
                pixels_sent++;
            end
        end
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_blocks.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic test_plain_defaults();
        send_pixel(8'h00, 9'd0, 8'd0);
        send_pixel(8'hFF, 9'd319, 8'd239);
        send_pixel(8'hA5, 9'd319, 8'd0);
        send_pixel(8'h5A, 9'd0, 8'd239);
        send_pixel(8'h3C, 9'd320, 8'd0);
        send_pixel(8'h12, 9'd0, 8'd240);
        send_pixel(8'h81, 9'd511, 8'd255);
        drain();
    endtask

    task automatic test_dither_channels();
        set_frame(319, 239, 1, 0, 0, 319, 239);
        send_pixel(8'hE0, 9'd0, 8'd0);
        send_pixel(8'h1C, 9'd1, 8'd1);
        send_pixel(8'h03, 9'd318, 8'd238);
        send_pixel(8'hFF, 9'd257, 8'd128);
        send_pixel(8'h00, 9'd100, 8'd3);
        send_pixel(8'h49, 9'd3, 8'd100);
        drain();
    endtask

    task automatic test_degenerate_frames();
        set_frame(0, 240, 0, 0, 0, 319, 239);
        send_pixel(8'h77, 9'd0, 8'd0);
        drain();
        set_frame(320, 0, 1, 0, 0, 319, 239);
        send_pixel(8'h77, 9'd0, 8'd0);
        drain();
        set_frame(321, 240, 0, 0, 0, 319, 239);
        send_pixel(8'h66, 9'd5, 8'd5);
        drain();
        set_frame(320, 241, 1, 0, 0, 319, 239);
        send_pixel(8'h66, 9'd5, 8'd5);
        drain();
    endtask

    task automatic test_region_clipping();
        set_frame(100, 50, 1, 10, 5, 319, 239);
        send_pixel(8'hDB, 9'd99, 8'd49);
        send_pixel(8'hDB, 9'd100, 8'd49);
        send_pixel(8'h24, 9'd9, 8'd5);
        send_pixel(8'h24, 9'd10, 8'd5);
        drain();
        set_frame(200, 100, 0, 60, 10, 40, 90);
        send_pixel(8'h99, 9'd50, 8'd20);
        drain();
        set_frame(1, 1, 1, 0, 0, 0, 0);
        send_pixel(8'h6D, 9'd0, 8'd0);
        send_pixel(8'h6D, 9'd1, 8'd0);
        drain();
    endtask

    task automatic test_random_frames();
        for (int p = 0; p < PHASES; p++)
        begin
            int r;
            int w;
            int h;
            int d;
            int xf;
            int yf;
            int xl;
            int yl;
            int w_top;
            int h_top;
            int x_end;
            int y_end;
            int x;
            int y;
            case (p)
                0:
                begin
                    w = 320; h = 240; d = 1; xf = 0; yf = 0; xl = 319; yl = 239;
                end
                1:
                begin
                    w = 1; h = 1; d = 1; xf = 0; yf = 0; xl = 0; yl = 0;
                end
                2:
                begin
                    w = 160; h = 120; d = 1; xf = 0; yf = 0; xl = 319; yl = 239;
                end
                default:
                begin
                    r = $urandom_range(99);
                    w = (r < 4) ? 0 : (r < 9) ? $urandom_range(321, 511) :
                        (r < 14) ? 320 : $urandom_range(1, 320);
                    r = $urandom_range(99);
                    h = (r < 4) ? 0 : (r < 9) ? $urandom_range(241, 255) :
                        (r < 14) ? 240 : $urandom_range(1, 240);
                    d = $urandom_range(1);
                    w_top = (w == 0) ? 0 : (w > 320) ? 319 : w - 1;
                    h_top = (h == 0) ? 0 : (h > 240) ? 239 : h - 1;
                    xl = ($urandom_range(3) == 0) ? 319 : $urandom_range(0, w_top);
                    yl = ($urandom_range(3) == 0) ? 239 : $urandom_range(0, h_top);
                    x_end = (xl < w_top) ? xl : w_top;
                    y_end = (yl < h_top) ? yl : h_top;
                    xf = ($urandom_range(19) == 0) ? $urandom_range(0, 319)
                                                   : $urandom_range(0, x_end);
                    yf = ($urandom_range(19) == 0) ? $urandom_range(0, 239)
                                                   : $urandom_range(0, y_end);
                end
            endcase
            w_top = (w == 0) ? 0 : (w > 320) ? 319 : w - 1;
            h_top = (h == 0) ? 0 : (h > 240) ? 239 : h - 1;
            x_end = (xl < w_top) ? xl : w_top;
            y_end = (yl < h_top) ? yl : h_top;
            set_frame(w, h, d, xf, yf, xl, yl);
            steady = (p == 4);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if ($urandom_range(99) < 85 && xf <= x_end && yf <= y_end)
                begin
                    x = $urandom_range(xf, x_end);
                    y = $urandom_range(yf, y_end);
                end
                else
                begin
                    x = $urandom_range(0, 511);
                    y = $urandom_range(0, 255);
                end
                send_pixel(8'($urandom_range(0, 255)), 9'(x), 8'(y));
            end
            drain();
            steady = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        block_t seen;
        block_t want;
        if (rst_n && done)
        begin
            seen = {accepted, top_row_address, bottom_row_address, pixel_top_left,
                    pixel_top_right, pixel_bottom_left, pixel_bottom_right};
            beats_checked++;
            if (accepted)
            begin
                blocks_written++;
            end
            if (expected_blocks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("cycle %0d: result beat with nothing pending", cycle_count);
                end
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("cycle %0d: exp acc=%0d top=%0d bot=%0d px=%h %h %h %h",
                                 cycle_count, want.accepted, want.top, want.bottom,
                                 want.tl, want.tr, want.bl, want.br);
                        $display("cycle %0d: got acc=%0d top=%0d bot=%0d px=%h %h %h %h",
                                 cycle_count, seen.accepted, seen.top, seen.bottom,
                                 seen.tl, seen.tr, seen.bl, seen.br);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats pending", cycle_count,
                     expected_blocks.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        pixel_colour = '0;
        source_x     = '0;
        source_y     = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        steady       = 1'b0;
        frame_cfg    = '{source_width: 9'd320, source_height: 8'd240, dither_enable: 1'b0,
                         region_x_first: 9'd0, region_y_first: 8'd0,
                         region_x_last: 9'd319, region_y_last: 8'd239};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_plain_defaults();
        test_dither_channels();
        test_degenerate_frames();
        test_region_clipping();
        test_random_frames();
        drain();
        repeat (8) @(negedge clk);
        $display("Sent %0d pixels under %0d register settings; %0d result beats checked.",
                 pixels_sent, settings_used, beats_checked);
        $display("%0d blocks written, %0d pixels rejected, %0d mismatches, %0d left pending.",
                 blocks_written, beats_checked - blocks_written, mismatches,
                 expected_blocks.size());
        if (mismatches == 0 && expected_blocks.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== pixel_double_bayer_dither_top.f =====
rtl/pdbd_pkg.sv
rtl/pdbd_check.sv
rtl/pdbd_place.sv
rtl/pdbd_emit.sv
rtl/pixel_double_bayer_dither_top.sv
rtl/pdbd_checker.sv
sim/pixel_double_bayer_dither_top_test.sv
